// ----- hw/rtl/call_stack_profiler_defines.svh -----
// Assertion macros shared by the profiler modules.
// Both sample on clk_i and stay quiet while rst_ni is low.
`ifndef CALL_STACK_PROFILER_DEFINES_SVH
`define CALL_STACK_PROFILER_DEFINES_SVH

// Property that must hold at every clock edge.
`define CSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define CSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/csp_pkg.sv -----
package csp_pkg;

  // Default sizes
  localparam int NUM_FUNCS_DEF   = 64;
  localparam int STACK_DEPTH_DEF = 32;

  // Field widths
  localparam int OP_W     = 2;
  localparam int FUNC_W   = 6;
  localparam int TIME_W   = 32;
  localparam int STATUS_W = 3;
  localparam int DEPTH_W  = 6;

  // Stream widths
  localparam int IN_USED_W   = OP_W + FUNC_W + 1 + TIME_W;
  localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;
  localparam int OUT_USED_W  = STATUS_W + 4 * TIME_W + DEPTH_W;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

  typedef enum logic [OP_W-1:0] {
    OP_ENTER = 2'd0,
    OP_EXIT  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_MISMATCH  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_FAULTED   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CALC,
    S_CLAMP,
    S_UPD
  } ctrl_state_e;

  // One call frame on the stack
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              trk;
    logic [TIME_W-1:0] start;
    logic [TIME_W-1:0] child;
  } frame_t;

  // Per-function totals entry
  typedef struct packed {
    logic [TIME_W-1:0] self_total;
    logic [TIME_W-1:0] child_total;
    logic [TIME_W-1:0] call_count;
    logic [TIME_W-1:0] max_self;
  } tot_t;

  // Result item
  typedef struct packed {
    logic [DEPTH_W-1:0]  stack_depth;
    logic [TIME_W-1:0]   max_self;
    logic [TIME_W-1:0]   call_count;
    logic [TIME_W-1:0]   child_total;
    logic [TIME_W-1:0]   self_total;
    logic [STATUS_W-1:0] status;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic calc;
    logic clamp;
    logic upd;
    logic sweep;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sweep_last;
    logic out_busy;
    logic op_clear;
  } sts_t;

  // Add two time values, saturating at all ones
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/csp_ctrl.sv -----
`include "call_stack_profiler_defines.svh"

module csp_ctrl import csp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  ctrl_state_e st_q, st_d;

  // State register; reset starts with a sweep of the totals table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLEAR;
    end else begin
      st_q <= st_d;
    end
  end

  // Next state and commands
  always_comb begin
    st_d       = st_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (st_q)
      S_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) st_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          st_d         = S_CALC;
        end
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        st_d       = S_CLAMP;
      end
      S_CLAMP: begin
        cmd_o.clamp = 1'b1;
        st_d        = S_UPD;
      end
      S_UPD: begin
        // hold while the previous result is still unread
        if (!sts_i.out_busy) begin
          cmd_o.upd = 1'b1;
          st_d      = sts_i.op_clear ? S_CLEAR : S_IDLE;
        end
      end
      default: st_d = S_CLEAR;
    endcase
  end

  `CSP_ASSERT_NEXT(a_clear_sweeps, cmd_o.upd && sts_i.op_clear, st_q == S_CLEAR, "clear not swept")
  `CSP_ASSERT_NEXT(a_accept_calc, cmd_o.accept, st_q == S_CALC, "accepted transaction not checked")

endmodule

// ----- hw/rtl/csp_datapath.sv -----
`include "call_stack_profiler_defines.svh"

module csp_datapath import csp_pkg::*; #(
  parameter int NUM_FUNCS   = NUM_FUNCS_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  op_e               in_op_i,
  input  logic [FUNC_W-1:0] in_fid_i,
  input  logic              in_trk_i,
  input  logic [TIME_W-1:0] in_now_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output out_t              out_o
);

  localparam int SIDX_W = $clog2(STACK_DEPTH);
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int TIDX_W = $clog2(NUM_FUNCS);
  localparam logic [CNT_W-1:0]  DEPTH_C    = CNT_W'(STACK_DEPTH);
  localparam logic [TIDX_W-1:0] LAST_IDX   = TIDX_W'(NUM_FUNCS - 1);
  localparam logic [31:0]       NUM_FUNCS_W = 32'(NUM_FUNCS);

  // Memories
  frame_t stack_mem [STACK_DEPTH];
  tot_t   tab_mem   [NUM_FUNCS];

  // Item and pipeline registers
  op_e               op_q;
  logic [FUNC_W-1:0] fid_q;
  logic              trk_q;
  logic [TIME_W-1:0] now_q;
  frame_t            top_q, par_q;
  tot_t              tab_q;
  logic              act_enter_q, act_exit_q;
  status_e           code_q;
  logic [TIME_W-1:0] elapsed_q, self_q, par_sum_q;
  logic [CNT_W-1:0]  open_q;
  logic              fault_q;
  logic [TIDX_W-1:0] clr_idx_q;
  logic              out_valid_q;
  out_t              out_q;

  // Stack pointers
  logic [CNT_W-1:0]  top_cnt, par_cnt;
  logic [SIDX_W-1:0] top_idx, par_idx, push_idx;
  assign top_cnt  = open_q - CNT_W'(1);
  assign par_cnt  = open_q - CNT_W'(2);
  assign top_idx  = top_cnt[SIDX_W-1:0];
  assign par_idx  = par_cnt[SIDX_W-1:0];
  assign push_idx = open_q[SIDX_W-1:0];

  // Table indexes
  logic [31:0]       in_fid_w, fid_w;
  logic [TIDX_W-1:0] in_tidx, tidx;
  logic              in_range;
  assign in_fid_w = 32'(in_fid_i);
  assign fid_w    = 32'(fid_q);
  assign in_tidx  = in_fid_w[TIDX_W-1:0];
  assign tidx     = fid_w[TIDX_W-1:0];
  assign in_range = fid_w < NUM_FUNCS_W;

  // Capture the transaction and read both memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= in_op_i;
      fid_q <= in_fid_i;
      trk_q <= in_trk_i;
      now_q <= in_now_i;
      top_q <= stack_mem[top_idx];
      par_q <= stack_mem[par_idx];
      tab_q <= tab_mem[in_tidx];
    end
  end

  // Check the event against the stack and fault state
  logic    act_enter_d, act_exit_d;
  status_e code_d;
  always_comb begin
    act_enter_d = 1'b0;
    act_exit_d  = 1'b0;
    code_d      = ST_OK;
    if (!fault_q && op_q == OP_ENTER) begin
      priority if (open_q >= DEPTH_C) code_d = ST_OVERFLOW;
      else act_enter_d = 1'b1;
    end
    if (!fault_q && op_q == OP_EXIT) begin
      priority if (open_q == '0) code_d = ST_UNDERFLOW;
      else if (top_q.func != fid_q) code_d = ST_MISMATCH;
      else act_exit_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      act_enter_q <= act_enter_d;
      act_exit_q  <= act_exit_d;
      code_q      <= code_d;
      elapsed_q   <= now_q - top_q.start;
    end
  end

  // Clamp self time and charge the parent
  always_ff @(posedge clk_i) begin
    if (cmd_i.clamp) begin
      self_q    <= (elapsed_q > top_q.child) ? elapsed_q - top_q.child : '0;
      par_sum_q <= sat_add(par_q.child, elapsed_q);
    end
  end

  // Update values
  logic             has_parent, acc;
  logic [CNT_W-1:0] open_d;
  logic             fault_d;
  logic [31:0]      open_w;
  frame_t           push_frame, par_frame;
  tot_t             tab_new, tot_out;
  out_t             out_d;

  assign has_parent = open_q > CNT_W'(1);
  assign acc        = act_exit_q && top_q.trk && in_range;
  assign fault_d    = fault_q || (code_q != ST_OK);
  assign open_w     = 32'(open_d);

  always_comb begin
    priority if (act_enter_q) open_d = open_q + CNT_W'(1);
    else if (act_exit_q) open_d = top_cnt;
    else open_d = open_q;
  end

  always_comb begin
    push_frame       = '0;
    push_frame.func  = fid_q;
    push_frame.trk   = trk_q;
    push_frame.start = now_q;
    par_frame        = par_q;
    par_frame.child  = par_sum_q;
  end

  always_comb begin
    tab_new.self_total  = sat_add(tab_q.self_total, self_q);
    tab_new.child_total = sat_add(tab_q.child_total, top_q.child);
    tab_new.call_count  = sat_add(tab_q.call_count, TIME_W'(1));
    tab_new.max_self    = (self_q > tab_q.max_self) ? self_q : tab_q.max_self;
    priority if (op_q == OP_CLEAR || !in_range) tot_out = '0;
    else if (acc) tot_out = tab_new;
    else tot_out = tab_q;
    out_d.status      = fault_q ? ST_FAULTED : code_q;
    out_d.self_total  = tot_out.self_total;
    out_d.child_total = tot_out.child_total;
    out_d.call_count  = tot_out.call_count;
    out_d.max_self    = tot_out.max_self;
    out_d.stack_depth = open_w[DEPTH_W-1:0];
  end

  // Stack write: push on enter, parent child time on exit
  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) begin
      if (act_enter_q) begin
        stack_mem[push_idx] <= push_frame;
      end else if (act_exit_q && has_parent) begin
        stack_mem[par_idx] <= par_frame;
      end
    end
  end

  // Table write: sweep zeros or store updated totals
  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep) begin
      tab_mem[clr_idx_q] <= '0;
    end else if (cmd_i.upd && acc) begin
      tab_mem[tidx] <= tab_new;
    end
  end

  // Stack depth, sticky fault and sweep address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q    <= '0;
      fault_q   <= 1'b0;
      clr_idx_q <= '0;
    end else begin
      if (cmd_i.upd) begin
        open_q  <= open_d;
        fault_q <= fault_d;
      end
      if (cmd_i.sweep) begin
        clr_idx_q <= (clr_idx_q == LAST_IDX) ? '0 : clr_idx_q + TIDX_W'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.upd) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) out_q <= out_d;
  end

  assign out_valid_o      = out_valid_q;
  assign out_o            = out_q;
  assign sts_o.sweep_last = clr_idx_q == LAST_IDX;
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;
  assign sts_o.op_clear   = op_q == OP_CLEAR;

  `CSP_ASSERT_NEXT(a_open_hold, !cmd_i.upd, $stable(open_q), "stack depth moved outside an update")
  `CSP_ASSERT_NEXT(a_fault_sticky, fault_q, fault_q, "fault flag dropped without reset")
  `CSP_ASSERT(a_open_range, open_q <= DEPTH_C, "stack depth beyond capacity")

endmodule

// ----- hw/rtl/call_stack_profiler.sv -----
// Call stack profiler. Events arrive on the s_axis channel, one per
// transaction: enter, exit, clear or read, each with a function id, a
// tracked bit and a millisecond time stamp. Every event returns exactly one
// result on the m_axis channel: status, the four totals of the addressed
// function after the event, and the open stack depth.
// Flow: the memories are read at acceptance, then come the frame check, the
// self time clamp, and the stack and table write-back that loads the result
// register; one event is in flight at a time, and the next one is accepted
// in the cycle after write-back at the earliest. A clear event is followed
// by a sweep of the totals table, one entry per cycle, during which
// s_axis_tready stays low.
// Reset: open depth and fault clear, then the same sweep zeroes the totals
// table before the first event is accepted.
// Stall: the result sits in an output register; the next event is accepted
// and processed meanwhile, and only its write-back waits until the pending
// result is taken.
module call_stack_profiler import csp_pkg::*; #(
  parameter int NUM_FUNCS   = NUM_FUNCS_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // opcode[1:0], func_id[7:2], tracked[8], now_ms[40:9], zero fill above
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // status[2:0], self_total[34:3], child_total[66:35], call_count[98:67],
  // max_self[130:99], stack_depth[136:131], zero fill above
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  cmd_t cmd;
  sts_t sts;
  out_t res;
  op_e  in_op;

  assign in_op = op_e'(s_axis_tdata[OP_W-1:0]);

  csp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  csp_datapath #(
    .NUM_FUNCS   (NUM_FUNCS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_op_i     (in_op),
    .in_fid_i    (s_axis_tdata[OP_W+FUNC_W-1:OP_W]),
    .in_trk_i    (s_axis_tdata[OP_W+FUNC_W]),
    .in_now_i    (s_axis_tdata[OP_W+FUNC_W+TIME_W:OP_W+FUNC_W+1]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_o       (res)
  );

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, res};

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench import csp_pkg::*;;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int RANDOM_ITEMS = 1850;
  localparam int DRAIN_CYCLES = NUM_FUNCS_DEF + 40;
  localparam int HOLD_CYCLES  = 400;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // One directed event, with an optional hand-typed result
  typedef struct {
    op_e               op;
    logic [FUNC_W-1:0] fid;
    logic              trk;
    logic [TIME_W-1:0] ms;
    bit                typed;
    out_t              want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Shadow of the profiler: call stack, totals tables and fault
  logic [FUNC_W-1:0] stk_func  [STACK_DEPTH_DEF];
  logic              stk_trk   [STACK_DEPTH_DEF];
  logic [TIME_W-1:0] stk_start [STACK_DEPTH_DEF];
  logic [TIME_W-1:0] stk_child [STACK_DEPTH_DEF];
  int                open_cnt = 0;
  logic [TIME_W-1:0] self_tot  [NUM_FUNCS_DEF];
  logic [TIME_W-1:0] child_tot [NUM_FUNCS_DEF];
  logic [TIME_W-1:0] calls_tot [NUM_FUNCS_DEF];
  logic [TIME_W-1:0] max_tot   [NUM_FUNCS_DEF];
  bit                faulted = 1'b0;

  out_t      expected_reports[$];
  stim_row_t dir_rows[$];
  int        err_cnt = 0;
  int        rx_cnt = 0;
  int        accepted_cnt = 0;
  int        hold_left = 0;
  bit        burst = 1'b0;
  int        cycles = 0;

  call_stack_profiler uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [TIME_W-1:0] add_sat(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    return (a > TIME_MAX - b) ? TIME_MAX : a + b;
  endfunction

  function automatic void wipe_totals();
    for (int f = 0; f < NUM_FUNCS_DEF; f++) begin
      self_tot[f] = '0;
      child_tot[f] = '0;
      calls_tot[f] = '0;
      max_tot[f] = '0;
    end
  endfunction

  // Apply one event to the shadow state and return the result it reports
  function automatic out_t profile_event(op_e op, logic [FUNC_W-1:0] fid, logic trk,
                                         logic [TIME_W-1:0] ms);
    out_t res;
    int top;
    logic [TIME_W-1:0] span, own, self_t;
    status_e st;
    st = ST_OK;
    top = open_cnt - 1;
    if (op == OP_CLEAR || op == OP_READ) begin
      if (op == OP_CLEAR) wipe_totals();
      if (faulted) st = ST_FAULTED;
    end else if (faulted) begin
      st = ST_FAULTED;
    end else if (op == OP_ENTER) begin
      if (open_cnt >= STACK_DEPTH_DEF) begin
        faulted = 1'b1;
        st = ST_OVERFLOW;
      end else begin
        stk_func[open_cnt] = fid;
        stk_trk[open_cnt] = trk;
        stk_start[open_cnt] = ms;
        stk_child[open_cnt] = '0;
        open_cnt++;
      end
    end else if (open_cnt == 0) begin
      faulted = 1'b1;
      st = ST_UNDERFLOW;
    end else if (stk_func[top] != fid) begin
      faulted = 1'b1;
      st = ST_MISMATCH;
    end else begin
      // Pop, charge the parent, clamp self time at zero
      span = ms - stk_start[top];
      own = stk_child[top];
      open_cnt = top;
      if (top > 0) stk_child[top-1] = add_sat(stk_child[top-1], span);
      self_t = (span > own) ? span - own : '0;
      if (stk_trk[top] && fid < NUM_FUNCS_DEF) begin
        self_tot[fid] = add_sat(self_tot[fid], self_t);
        child_tot[fid] = add_sat(child_tot[fid], own);
        calls_tot[fid] = add_sat(calls_tot[fid], 1);
        if (self_t > max_tot[fid]) max_tot[fid] = self_t;
      end
    end
    res = '0;
    res.status = st;
    if (fid < NUM_FUNCS_DEF) begin
      res.self_total = self_tot[fid];
      res.child_total = child_tot[fid];
      res.call_count = calls_tot[fid];
      res.max_self = max_tot[fid];
    end
    res.stack_depth = open_cnt[DEPTH_W-1:0];
    return res;
  endfunction

  function automatic out_t mk_out(status_e st, logic [TIME_W-1:0] s, logic [TIME_W-1:0] c,
                                  logic [TIME_W-1:0] n, logic [TIME_W-1:0] m, int d);
    out_t r;
    r.status = st;
    r.self_total = s;
    r.child_total = c;
    r.call_count = n;
    r.max_self = m;
    r.stack_depth = d[DEPTH_W-1:0];
    return r;
  endfunction

  function automatic void add_row(op_e op, logic [FUNC_W-1:0] fid, logic trk,
                                  logic [TIME_W-1:0] ms, bit typed, out_t want);
    stim_row_t r;
    r.op = op;
    r.fid = fid;
    r.trk = trk;
    r.ms = ms;
    r.typed = typed;
    r.want = want;
    dir_rows.push_back(r);
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic flag_error(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic check_field(string name, logic [TIME_W-1:0] got, logic [TIME_W-1:0] want);
    if (got !== want)
      flag_error($sformatf("result %0d %s: got %0h, want %0h", rx_cnt, name, got, want));
  endtask

  // Offer one event, wait for the transaction, then record its expected result
  task automatic send_event(op_e op, logic [FUNC_W-1:0] fid, logic trk, logic [TIME_W-1:0] ms,
                            bit typed, out_t want);
    int gap;
    out_t predicted;
    gap = (burst || hold_left > 0) ? 0 : idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(IN_TDATA_W-IN_USED_W){1'b0}}, ms, trk, fid, op};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = profile_event(op, fid, trk, ms);
    expected_reports.push_back(typed ? want : predicted);
    accepted_cnt++;
  endtask

  // Receiver: random back-pressure, one long hold-off, and result checking
  initial begin
    out_t got, w;
    int stall_left;
    bit held;
    stall_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = out_t'(m_axis_tdata[OUT_USED_W-1:0]);
        if (expected_reports.size() == 0) begin
          flag_error($sformatf("unexpected result, status %0d depth %0d",
                               got.status, got.stack_depth));
        end else begin
          w = expected_reports.pop_front();
          check_field("status", got.status, w.status);
          check_field("self_total", got.self_total, w.self_total);
          check_field("child_total", got.child_total, w.child_total);
          check_field("call_count", got.call_count, w.call_count);
          check_field("max_self", got.max_self, w.max_self);
          check_field("stack_depth", got.stack_depth, w.stack_depth);
        end
        rx_cnt++;
      end
      if (!held && accepted_cnt >= 400) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!burst && $urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  // Watchdog
  initial begin
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Stimulus
  initial begin
    logic [TIME_W-1:0] clk_ms, ms;
    logic [FUNC_W-1:0] fid;
    int target, r, kind;
    wipe_totals();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty reads, extreme ids, time wrap
    add_row(OP_READ, 0, 1'b0, 32'h0, 1'b1, mk_out(ST_OK, 0, 0, 0, 0, 0));
    add_row(OP_READ, 63, 1'b1, TIME_MAX, 1'b1, mk_out(ST_OK, 0, 0, 0, 0, 0));
    add_row(OP_ENTER, 63, 1'b1, 32'hFFFF_FFF0, 1'b1, mk_out(ST_OK, 0, 0, 0, 0, 1));
    add_row(OP_ENTER, 0, 1'b1, 32'h10, 1'b1, mk_out(ST_OK, 0, 0, 0, 0, 2));
    add_row(OP_EXIT, 0, 1'b0, 32'h20, 1'b0, '0);
    add_row(OP_EXIT, 63, 1'b1, 32'h30, 1'b0, '0);
    // Self time clamps at zero; untracked child leaves totals alone
    add_row(OP_ENTER, 5, 1'b1, 32'd100, 1'b0, '0);
    add_row(OP_ENTER, 6, 1'b0, 32'd0, 1'b0, '0);
    add_row(OP_EXIT, 6, 1'b1, 32'd1000, 1'b0, '0);
    add_row(OP_EXIT, 5, 1'b0, 32'd200, 1'b0, '0);
    // Saturation of totals and of the parent's child time
    add_row(OP_ENTER, 10, 1'b1, 32'd0, 1'b0, '0);
    add_row(OP_ENTER, 11, 1'b1, 32'd1, 1'b0, '0);
    add_row(OP_EXIT, 11, 1'b0, 32'd0, 1'b0, '0);
    add_row(OP_ENTER, 11, 1'b1, 32'd1, 1'b0, '0);
    add_row(OP_EXIT, 11, 1'b0, 32'd0, 1'b0, '0);
    add_row(OP_EXIT, 10, 1'b0, TIME_MAX, 1'b0, '0);
    add_row(OP_READ, 11, 1'b0, 32'h1234_5678, 1'b0, '0);
    // Clear zeroes totals but keeps open frames
    add_row(OP_CLEAR, 11, 1'b0, 32'h0, 1'b1, mk_out(ST_OK, 0, 0, 0, 0, 0));
    add_row(OP_READ, 10, 1'b0, 32'h0, 1'b1, mk_out(ST_OK, 0, 0, 0, 0, 0));
    add_row(OP_ENTER, 42, 1'b1, 32'h5555_5555, 1'b0, '0);
    add_row(OP_CLEAR, 42, 1'b1, TIME_MAX, 1'b1, mk_out(ST_OK, 0, 0, 0, 0, 1));
    add_row(OP_EXIT, 42, 1'b0, 32'hAAAA_AAAA, 1'b0, '0);
    add_row(OP_READ, 42, 1'b1, 32'h0, 1'b0, '0);
    foreach (dir_rows[i])
      send_event(dir_rows[i].op, dir_rows[i].fid, dir_rows[i].trk, dir_rows[i].ms,
                 dir_rows[i].typed, dir_rows[i].want);

    // Random: well-formed call trees walking toward a target depth
    clk_ms = $urandom;
    target = 4;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) burst = ($urandom_range(0, 3) == 0);
      if (open_cnt == target)
        target = ($urandom_range(0, 7) == 0) ? STACK_DEPTH_DEF : $urandom_range(0, 12);
      // advance the clock, with occasional jumps that wrap or go backward
      r = $urandom_range(0, 99);
      if (r < 90) clk_ms = clk_ms + $urandom_range(0, 50);
      else if (r < 96) clk_ms = clk_ms + $urandom_range(0, 32'hFFFF);
      else clk_ms = $urandom;
      r = $urandom_range(0, 99);
      if (r < 2) begin
        send_event(OP_CLEAR, FUNC_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)),
                   $urandom, 1'b0, '0);
      end else if (r < 12) begin
        send_event(OP_READ, FUNC_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)),
                   $urandom, 1'b0, '0);
      end else if (open_cnt == 0 || open_cnt < target) begin
        send_event(OP_ENTER, FUNC_W'($urandom_range(0, 63)), ($urandom_range(0, 3) != 0),
                   clk_ms, 1'b0, '0);
      end else begin
        send_event(OP_EXIT, stk_func[open_cnt-1], 1'($urandom_range(0, 1)), clk_ms, 1'b0, '0);
      end
    end
    burst = 1'b0;

    // Faults are sticky until reset, so provoke exactly one kind at the end
    kind = $urandom_range(0, 2);
    if (kind == 0) begin
      if (open_cnt == 0) send_event(OP_ENTER, 7, 1'b1, clk_ms, 1'b0, '0);
      fid = stk_func[open_cnt-1] ^ 6'd1;
      send_event(OP_EXIT, fid, 1'b0, clk_ms + 5, 1'b0, '0);
    end else if (kind == 1) begin
      while (open_cnt > 0) begin
        clk_ms = clk_ms + $urandom_range(0, 9);
        send_event(OP_EXIT, stk_func[open_cnt-1], 1'b0, clk_ms, 1'b0, '0);
      end
      send_event(OP_EXIT, FUNC_W'($urandom_range(0, 63)), 1'b0, clk_ms, 1'b0, '0);
    end else begin
      while (open_cnt < STACK_DEPTH_DEF) begin
        clk_ms = clk_ms + $urandom_range(0, 9);
        send_event(OP_ENTER, FUNC_W'($urandom_range(0, 63)), 1'b1, clk_ms, 1'b0, '0);
      end
      send_event(OP_ENTER, FUNC_W'($urandom_range(0, 63)), 1'b1, clk_ms, 1'b0, '0);
    end

    // While faulted, enter and exit are ignored; clear and read still act
    ms = $urandom;
    send_event(OP_ENTER, FUNC_W'($urandom_range(0, 63)), 1'b1, ms, 1'b0, '0);
    send_event(OP_EXIT, FUNC_W'($urandom_range(0, 63)), 1'b0, ms + 3, 1'b0, '0);
    send_event(OP_READ, stk_func[0], 1'b0, ms, 1'b0, '0);
    send_event(OP_CLEAR, FUNC_W'($urandom_range(0, 63)), 1'b0, ms, 1'b0, '0);
    send_event(OP_READ, FUNC_W'($urandom_range(0, 63)), 1'b1, ms, 1'b0, '0);
    s_axis_tvalid <= 1'b0;

    // Drain, then let any stray result show up
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
